>>> src/multichannel_current_pd_regulator_assert.svh
// Assertion macros for the multichannel current regulator.
// Expects clk and rst to be visible where the macros are used.
`ifndef MULTICHANNEL_CURRENT_PD_REGULATOR_ASSERT_SVH
`define MULTICHANNEL_CURRENT_PD_REGULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mcpd_pkg.sv
// Shared types and constants for the multichannel current regulator.
// No dependencies; every other file of the block but the assertion macro header imports this package.
`timescale 1ns / 1ps

package mcpd_pkg;

  localparam int DEFAULT_CHANNELS = 4;

  localparam int CHAN_W   = 2;
  localparam int SENSE_W  = 12;
  localparam int TARGET_W = 16;
  localparam int CODE_W   = 8;
  localparam int CUR_W    = 28;
  localparam int CFG_W    = 64;
  localparam int LANE_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam int MUL_A_W = CUR_W + 1;
  localparam int MUL_B_W = LANE_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = MUL_P_W + 1;
  localparam int FRAC_SHIFT = 28;
  localparam int ADJ_W   = SUM_W - FRAC_SHIFT;
  localparam int FILT_SHIFT = 16;
  localparam int TARGET_SHIFT = 12;

  localparam logic [MUL_B_W-1:0] FILT_KEEP = MUL_B_W'(65405);
  localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};
  localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((64'd1 << FRAC_SHIFT) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_CURRENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAINS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAINS  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_AVG,
    S_PROP,
    S_DERIV,
    S_SUM,
    S_ADJ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

>>> src/mcpd_if.sv
// Request and result channel interfaces of the multichannel current regulator.
// Depends on mcpd_pkg for the field widths.
`timescale 1ns / 1ps

interface mcpd_in_if import mcpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   channel;
  logic [SENSE_W-1:0]  sense_code;
  logic [TARGET_W-1:0] target_current;

  modport source (output valid, channel, sense_code, target_current, input ready);
  modport sink (input valid, channel, sense_code, target_current, output ready);
endinterface

interface mcpd_out_if import mcpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_channel;
  logic              drive_enable;
  logic [CODE_W-1:0] drive_code;

  modport source (output valid, out_channel, drive_enable, drive_code, input ready);
  modport sink (input valid, out_channel, drive_enable, drive_code, output ready);
endinterface

>>> src/mcpd_mul.sv
// Shared signed multiplier of the regulator, with a registered product.
// Depends on mcpd_pkg for the operand struct and widths.
`timescale 1ns / 1ps

module mcpd_mul import mcpd_pkg::*; (
  input  logic                       clk,
  input  mul_op_t                    op,
  output logic signed [MUL_P_W-1:0]  product
);

  always_ff @(posedge clk) begin
    product <= MUL_P_W'(op.a) * MUL_P_W'(op.b);
  end

endmodule

>>> src/multichannel_current_pd_regulator.sv
// Top level of the multichannel current regulator: sequencer, channel state and config.
// Depends on mcpd_pkg, mcpd_if, mcpd_mul and the assertion macro header.
`timescale 1ns / 1ps
`include "multichannel_current_pd_regulator_assert.svh"

// Each request updates one channel's filtered current and runs a PD step on its
// 8-bit drive code. An enabled request goes from acceptance through S_FILT, S_AVG,
// S_PROP, S_DERIV, S_SUM and S_ADJ to S_DONE, since the filter, proportional and
// derivative products go one after another through a single 29x17 multiplier,
// followed by the add, truncate and clamp steps. A new request is taken only in
// S_IDLE, so one request is handled at a time. A request for a disabled channel or a
// channel beyond CHANNELS skips the arithmetic and goes from acceptance straight to
// S_DONE. From S_DONE a finished result enters an output register and sits there
// until taken; a further finished result waits in S_DONE until the register frees.
// Reset clears all channel state and the gain and threshold registers.
module multichannel_current_pd_regulator import mcpd_pkg::*; #(
  parameter int CHANNELS = DEFAULT_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mcpd_in_if.sink              samples,
  mcpd_out_if.source           results
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CFG_W-1:0] min_currents;
  logic [CFG_W-1:0] prop_gains;
  logic [CFG_W-1:0] deriv_gains;

  state_t state, state_next;

  logic [CHAN_W-1:0]   ch;
  logic [SENSE_W-1:0]  sample;
  logic [TARGET_W-1:0] target;
  logic                skip;
  logic                live;

  logic [CUR_W-1:0]  filt [CHANNELS];
  logic [CUR_W-1:0]  prev [CHANNELS];
  logic [CODE_W-1:0] code_mem [CHANNELS];

  logic [CUR_W-1:0]          avg;
  logic signed [MUL_P_W-1:0] acc;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ADJ_W-1:0]   adj;

  logic              out_valid;
  logic [CHAN_W-1:0] out_channel;
  logic              out_enable;
  logic [CODE_W-1:0] out_code;

  logic                      accept;
  logic                      out_free;
  logic                      live_in;
  logic                      skip_in;
  logic [CH_IDX_W-1:0]       ch_idx;
  logic [LANE_W-1:0]         kp;
  logic [LANE_W-1:0]         kd;
  logic [19:0]               sample_x131;
  logic [CUR_W:0]            avg_sum;
  logic [CUR_W-1:0]          avg_sat;
  logic signed [MUL_A_W-1:0] err;
  logic signed [MUL_A_W-1:0] delta;
  logic signed [SUM_W-1:0]   sum_biased;
  logic signed [ADJ_W:0]     code_wide;
  logic [CODE_W-1:0]         code_sat;
  mul_op_t                   mul_op;
  logic signed [MUL_P_W-1:0] product;

  mcpd_mul u_mul (
    .clk     (clk),
    .op      (mul_op),
    .product (product)
  );

  assign accept   = samples.valid && samples.ready;
  assign out_free = !out_valid || results.ready;
  assign samples.ready = (state == S_IDLE);

  assign live_in = ({1'b0, samples.channel} < 3'(CHANNELS));
  assign skip_in = !live_in ||
                   (samples.target_current <= min_currents[samples.channel*LANE_W +: LANE_W]);

  assign ch_idx = ch[CH_IDX_W-1:0];
  assign kp = prop_gains[ch*LANE_W +: LANE_W];
  assign kd = deriv_gains[ch*LANE_W +: LANE_W];

  assign sample_x131 = (20'(sample) << 7) + (20'(sample) << 1) + 20'(sample);
  assign avg_sum = {1'b0, product[CUR_W+FILT_SHIFT-1:FILT_SHIFT]} + (CUR_W+1)'(sample_x131);
  assign avg_sat = avg_sum[CUR_W] ? CUR_MAX : avg_sum[CUR_W-1:0];

  assign err   = $signed({1'b0, avg}) - $signed({1'b0, target, {TARGET_SHIFT{1'b0}}});
  assign delta = $signed({1'b0, avg}) - $signed({1'b0, prev[ch_idx]});

  assign sum_biased = sum + $signed(sum[SUM_W-1] ? TRUNC_BIAS : '0);

  assign code_wide = $signed({{(ADJ_W+1-CODE_W){1'b0}}, code_mem[ch_idx]}) -
                     $signed({adj[ADJ_W-1], adj});
  assign code_sat = code_wide[ADJ_W] ? '0 :
                    (code_wide[ADJ_W-1:CODE_W] != '0) ? {CODE_W{1'b1}} :
                    code_wide[CODE_W-1:0];

  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    case (state)
      S_FILT: begin
        mul_op.a = $signed({1'b0, filt[ch_idx]});
        mul_op.b = $signed(FILT_KEEP);
      end
      S_PROP: begin
        mul_op.a = err;
        mul_op.b = $signed({1'b0, kp});
      end
      S_DERIV: begin
        mul_op.a = delta;
        mul_op.b = $signed({1'b0, kd});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = skip_in ? S_DONE : S_FILT;
        end
      end
      S_FILT:  state_next = S_AVG;
      S_AVG:   state_next = S_PROP;
      S_PROP:  state_next = S_DERIV;
      S_DERIV: state_next = S_SUM;
      S_SUM:   state_next = S_ADJ;
      S_ADJ:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_currents <= '0;
      prop_gains   <= '0;
      deriv_gains  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_CURRENTS: min_currents <= cfg_data;
        REG_PROP_GAINS:   prop_gains   <= cfg_data;
        REG_DERIV_GAINS:  deriv_gains  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch     <= samples.channel;
      sample <= samples.sense_code;
      target <= samples.target_current;
      skip   <= skip_in;
      live   <= live_in;
    end
    if (state == S_AVG) begin
      avg <= avg_sat;
    end
    if (state == S_DERIV) begin
      acc <= product;
    end
    if (state == S_SUM) begin
      sum <= SUM_W'(acc) + SUM_W'(product);
    end
    if (state == S_ADJ) begin
      adj <= ADJ_W'(sum_biased >>> FRAC_SHIFT);
    end
    if (state == S_DONE && out_free) begin
      out_channel <= ch;
      out_enable  <= !skip;
      out_code    <= skip ? '0 : code_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        filt[i]     <= '0;
        prev[i]     <= '0;
        code_mem[i] <= '0;
      end
    end else if (state == S_DONE && out_free && live) begin
      if (skip) begin
        code_mem[ch_idx] <= '0;
      end else begin
        filt[ch_idx]     <= avg;
        prev[ch_idx]     <= avg;
        code_mem[ch_idx] <= code_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid        = out_valid;
  assign results.out_channel  = out_channel;
  assign results.drive_enable = out_enable;
  assign results.drive_code   = out_code;

  `MCPD_ASSERT_NEXT(a_accept_starts, samples.valid && samples.ready, state != S_IDLE, "accepted request did not start")
  `MCPD_ASSERT_NEXT(a_done_presents, state == S_DONE && out_free, results.valid, "finished request not presented")
  `MCPD_ASSERT_SAME(a_disabled_zero, results.valid && !results.drive_enable, results.drive_code == '0, "disabled result has nonzero code")

endmodule

>>> tb/sv/multichannel_current_pd_regulator_tb.sv
// Self-checking testbench for the multichannel current regulator: directed and random requests.
// Depends on mcpd_pkg, mcpd_if and multichannel_current_pd_regulator from the RTL.
`timescale 1ns / 1ps

module multichannel_current_pd_regulator_tb;
  import mcpd_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 40;
  localparam int CHANNEL_COUNT = DEFAULT_CHANNELS;
  localparam int RANDOM_REQUESTS = 950;
  localparam int PHASES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint FILTER_KEEP = 65405;
  localparam longint FILTER_GAIN = 131;
  localparam longint CURRENT_MAX = 64'h0FFF_FFFF;
  localparam int GAIN_SHIFT = 28;

  typedef struct {
    logic [CHAN_W-1:0] channel;
    logic              enable;
    logic [CODE_W-1:0] code;
  } drive_result_t;

  class drive_code_board;
    logic [CFG_W-1:0]  min_currents;
    logic [CFG_W-1:0]  prop_gains;
    logic [CFG_W-1:0]  deriv_gains;
    logic [CUR_W-1:0]  filtered [CHANNEL_COUNT];
    logic [CUR_W-1:0]  prev_filtered [CHANNEL_COUNT];
    logic [CODE_W-1:0] res_code [CHANNEL_COUNT];
    drive_result_t     pending_drives [$];
    int                errors;

    function new();
      min_currents = '0;
      prop_gains = '0;
      deriv_gains = '0;
      errors = 0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        filtered[c] = '0;
        prev_filtered[c] = '0;
        res_code[c] = '0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_MIN_CURRENTS: min_currents = value;
        REG_PROP_GAINS: prop_gains = value;
        REG_DERIV_GAINS: deriv_gains = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction

    function void note_request(logic [CHAN_W-1:0] ch, logic [SENSE_W-1:0] sense,
                               logic [TARGET_W-1:0] target);
      drive_result_t want;
      logic [LANE_W-1:0] thr;
      longint avg, target_s, err, delta, kp, kd, sum, adj, code;
      want.channel = ch;
      want.enable = 1'b0;
      want.code = '0;
      if (ch >= CHANNEL_COUNT) begin
        pending_drives.push_back(want);
        return;
      end
      thr = min_currents[LANE_W*ch +: LANE_W];
      if (target <= thr) begin
        res_code[ch] = '0;
        pending_drives.push_back(want);
        return;
      end
      avg = ((longint'(filtered[ch]) * FILTER_KEEP) >>> 16) + longint'(sense) * FILTER_GAIN;
      if (avg > CURRENT_MAX) avg = CURRENT_MAX;
      target_s = longint'(target);
      kp = longint'(prop_gains[LANE_W*ch +: LANE_W]);
      kd = longint'(deriv_gains[LANE_W*ch +: LANE_W]);
      err = avg - (target_s <<< TARGET_SHIFT);
      delta = avg - longint'(prev_filtered[ch]);
      sum = kp * err + kd * delta;
      adj = sum / (longint'(1) <<< GAIN_SHIFT);
      code = longint'(res_code[ch]) - adj;
      if (code > 255) code = 255;
      if (code < 0) code = 0;
      filtered[ch] = avg[CUR_W-1:0];
      prev_filtered[ch] = avg[CUR_W-1:0];
      res_code[ch] = code[CODE_W-1:0];
      want.enable = 1'b1;
      want.code = code[CODE_W-1:0];
      pending_drives.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
    endtask

    task check_drive(logic [CHAN_W-1:0] ch, logic en, logic [CODE_W-1:0] code);
      drive_result_t want;
      if (pending_drives.size() == 0) begin
        report($sformatf("result on channel %0d with no request outstanding", ch));
        return;
      end
      want = pending_drives.pop_front();
      if (ch !== want.channel)
        report($sformatf("out_channel %0d, expected %0d", ch, want.channel));
      if (en !== want.enable)
        report($sformatf("channel %0d drive_enable %b, expected %b", want.channel, en,
                         want.enable));
      if (code !== want.code)
        report($sformatf("channel %0d drive_code %0d, expected %0d", want.channel, code,
                         want.code));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mcpd_in_if samples_bus ();
  mcpd_out_if results_bus ();

  drive_code_board drive_board;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  int gap_max = 6;
  int stall_left = 0;
  logic [15:0] stall_phase = '0;

  multichannel_current_pd_regulator i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(samples_bus),
    .results(results_bus)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** multichannel_current_pd_regulator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && results_bus.valid === 1'b1 && results_bus.ready === 1'b1)
      drive_board.check_drive(results_bus.out_channel, results_bus.drive_enable,
                              results_bus.drive_code);
  end

  // The receiver cycles through steady, random, long-stall and alternating patterns.
  always @(negedge clk) begin
    stall_phase = stall_phase + 1'b1;
    if (stall_left != 0) begin
      stall_left--;
      results_bus.ready <= 1'b0;
    end else begin
      case (stall_phase[9:8])
        2'd0: results_bus.ready <= 1'b1;
        2'd1: results_bus.ready <= ($urandom_range(0, 3) != 0);
        2'd2: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
            results_bus.ready <= 1'b0;
          end else begin
            results_bus.ready <= 1'b1;
          end
        end
        default: results_bus.ready <= stall_phase[0];
      endcase
    end
  end

  task automatic send_request(input logic [CHAN_W-1:0] ch, input logic [SENSE_W-1:0] sense,
                              input logic [TARGET_W-1:0] target);
    @(negedge clk);
    samples_bus.valid <= 1'b1;
    samples_bus.channel <= ch;
    samples_bus.sense_code <= sense;
    samples_bus.target_current <= target;
    @(posedge clk);
    while (samples_bus.ready !== 1'b1) @(posedge clk);
    drive_board.note_request(ch, sense, target);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        samples_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic request_paced(input logic [CHAN_W-1:0] ch, input logic [SENSE_W-1:0] sense,
                               input logic [TARGET_W-1:0] target);
    send_request(ch, sense, target);
    pace_sender();
  endtask

  // The sender holds off here until every outstanding request has its result.
  task automatic wait_drained();
    @(negedge clk);
    samples_bus.valid <= 1'b0;
    while (drive_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    drive_board.set_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int quota);
    int sent, ch, thr, kind, base, run, s, t;
    sent = 0;
    while (sent < quota) begin
      ch = $urandom_range(0, CHANNEL_COUNT - 1);
      thr = int'(drive_board.min_currents[LANE_W*ch +: LANE_W]);
      kind = $urandom_range(0, 9);
      if (kind < 7 && thr != 65535) begin
        base = $urandom_range(0, 4095);
        if (kind < 4) t = base * 16 + int'($urandom_range(0, 512)) - 256;
        else t = $urandom_range(thr + 1, 65535);
        if (t <= thr) t = thr + 1;
        if (t > 65535) t = 65535;
        run = $urandom_range(3, 12);
        repeat (run) begin
          s = base + int'($urandom_range(0, 128)) - 64;
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
          request_paced(ch[CHAN_W-1:0], s[SENSE_W-1:0], t[TARGET_W-1:0]);
          sent++;
        end
      end else if (kind < 9) begin
        t = $urandom_range(0, thr);
        request_paced(ch[CHAN_W-1:0], SENSE_W'($urandom_range(0, 4095)), t[TARGET_W-1:0]);
        sent++;
      end else begin
        request_paced(ch[CHAN_W-1:0], SENSE_W'($urandom_range(0, 4095)),
                      TARGET_W'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] mins, kps, kds;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples_bus.valid = 1'b0;
    samples_bus.channel = '0;
    samples_bus.sense_code = '0;
    samples_bus.target_current = '0;
    results_bus.ready = 1'b0;
    drive_board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    request_paced(2'd0, 12'd0, 16'h0000);
    request_paced(2'd1, 12'hFFF, 16'h0001);
    wait_drained();

    write_register(REG_MIN_CURRENTS, {16'h0800, 16'hFFFF, 16'h0000, 16'h0100});
    write_register(REG_PROP_GAINS, {4{16'h1000}});
    write_register(REG_DERIV_GAINS, {4{16'h0800}});
    write_register(REG_SPARE, {$urandom, $urandom});

    request_paced(2'd0, 12'd100, 16'h0100);
    request_paced(2'd0, 12'd100, 16'h0101);
    request_paced(2'd0, 12'hFFF, 16'hFFFF);
    request_paced(2'd1, 12'd0, 16'h0001);
    repeat (4) request_paced(2'd1, 12'd0, 16'hFFFF);
    request_paced(2'd2, 12'hFFF, 16'hFFFF);
    request_paced(2'd2, 12'd0, 16'h0000);
    repeat (3) request_paced(2'd3, 12'd0, 16'h8000);
    request_paced(2'd3, 12'hFFF, 16'h0000);
    request_paced(2'd3, 12'hFFF, 16'h0900);
    repeat (4) request_paced(2'd1, 12'hFFF, 16'h0001);
    request_paced(2'd3, 12'hFFF, 16'h0801);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      gap_max = 6;
      case (p)
        0: begin
          for (int l = 0; l < CHANNEL_COUNT; l++)
            mins[LANE_W*l +: LANE_W] = LANE_W'($urandom_range(0, 1024));
          kps = {$urandom, $urandom};
          kds = {$urandom, $urandom};
        end
        1: begin
          mins = '0;
          kps = '1;
          kds = '1;
        end
        2: begin
          mins = {16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom_range(0, 255))};
          kps = {$urandom, $urandom};
          kds = '0;
          gap_max = 0;
        end
        3: begin
          mins = {$urandom, $urandom};
          for (int l = 0; l < CHANNEL_COUNT; l++)
            kps[LANE_W*l +: LANE_W] = LANE_W'($urandom_range(0, 8192));
          kds = '1;
        end
        4: begin
          mins = '0;
          kps = '0;
          kds = '0;
        end
        default: begin
          for (int l = 0; l < CHANNEL_COUNT; l++)
            mins[LANE_W*l +: LANE_W] = LANE_W'($urandom_range(0, 4096));
          kps = {$urandom, $urandom};
          kds = {$urandom, $urandom};
          gap_max = 12;
        end
      endcase
      write_register(REG_MIN_CURRENTS, mins);
      write_register(REG_PROP_GAINS, kps);
      write_register(REG_DERIV_GAINS, kds);
      write_register(REG_SPARE, {$urandom, $urandom});
      random_phase(RANDOM_REQUESTS / PHASES);
    end

    wait_drained();
    if (drive_board.errors == 0 && drive_board.pending() == 0) begin
      $display("** multichannel_current_pd_regulator: PASSED **");
    end else begin
      $display("** multichannel_current_pd_regulator: FAILED **");
    end
    $finish;
  end

endmodule
